// File: sv/dprc_pkg.sv
`timescale 1ns / 1ps
package dprc_pkg;

    localparam int RAW_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF = 16;
    localparam int WORD_BITS      = 16;
    localparam int TICK_BITS      = 16;

    localparam logic [TICK_BITS-1:0] PERIOD_RESET = 16'd6;
    localparam logic [TICK_BITS-1:0] TICK_MAX     = '1;

    localparam logic [1:0] CS_NONE = 2'd0;
    localparam logic [1:0] CS_ONE  = 2'd1;
    localparam logic [1:0] CS_TWO  = 2'd2;

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_WORD = 2'd1,
        FN_CAL  = 2'd2,
        FN_LOAD = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_S1_HIGH = 5'b00010,
        PH_S1_LOW  = 5'b00100,
        PH_S2_HIGH = 5'b01000,
        PH_S2_LOW  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic emit;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic cal_end;
        logic div_last;
    } t_ctl_sts;

endpackage

// File: sv/dprc_cfg_if.sv
`timescale 1ns / 1ps
interface dprc_cfg_if;
    import dprc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TICK_BITS-1:0] read_period_ticks;

    modport source (output valid, output read_period_ticks, input ready);
    modport sink (input valid, input read_period_ticks, output ready);
endinterface

// File: sv/dprc_in_if.sv
`timescale 1ns / 1ps
interface dprc_in_if #(
    parameter int RAW_BITS   = dprc_pkg::RAW_BITS_DEF,
    parameter int COUNT_BITS = dprc_pkg::COUNT_BITS_DEF
);
    import dprc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [WORD_BITS-1:0]  rx_word;
    logic [COUNT_BITS-1:0] cal_count;
    logic                  sensor_sel;
    logic [RAW_BITS-1:0]   offset_value;

    modport source (
        output valid, output func, output rx_word, output cal_count,
        output sensor_sel, output offset_value, input ready
    );
    modport sink (
        input valid, input func, input rx_word, input cal_count,
        input sensor_sel, input offset_value, output ready
    );
endinterface

// File: sv/dprc_out_if.sv
`timescale 1ns / 1ps
interface dprc_out_if #(
    parameter int RAW_BITS = dprc_pkg::RAW_BITS_DEF
);
    import dprc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 chip_select;
    logic                       send_request;
    logic                       reading_done;
    logic signed [RAW_BITS:0]   pressure_one;
    logic signed [RAW_BITS:0]   pressure_two;
    logic [RAW_BITS-1:0]        offset_one;
    logic [RAW_BITS-1:0]        offset_two;
    logic                       save_offsets;

    modport source (
        output valid, output chip_select, output send_request, output reading_done,
        output pressure_one, output pressure_two, output offset_one, output offset_two,
        output save_offsets, input ready
    );
    modport sink (
        input valid, input chip_select, input send_request, input reading_done,
        input pressure_one, input pressure_two, input offset_one, input offset_two,
        input save_offsets, output ready
    );
endinterface

// File: sv/dprc_ctrl.sv
`timescale 1ns / 1ps
module dprc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dprc_pkg::t_ctl_sts i_sts,
    output dprc_pkg::t_ctl_cmd o_cmd
);
    import dprc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.cal_end) begin
                        n_state = ST_DIV;
                    end else begin
                        o_cmd.load_out = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cal_end_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.cal_end) |=> (r_state == ST_DIV))
        else $error("calibration end did not start the divider");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_sts.out_free) |=> (r_state == ST_IDLE))
        else $error("emit did not return to idle");

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("output register loaded while full");

endmodule

// File: sv/dprc_dp.sv
`timescale 1ns / 1ps
module dprc_dp #(
    parameter int RAW_BITS   = dprc_pkg::RAW_BITS_DEF,
    parameter int COUNT_BITS = dprc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dprc_pkg::t_ctl_cmd            i_cmd,
    output dprc_pkg::t_ctl_sts            o_sts,
    input  logic                          i_cfg_we,
    input  logic [dprc_pkg::TICK_BITS-1:0] i_cfg_data,
    input  logic [1:0]                    i_func,
    input  logic [dprc_pkg::WORD_BITS-1:0] i_rx_word,
    input  logic [COUNT_BITS-1:0]         i_cal_count,
    input  logic                          i_sensor_sel,
    input  logic [RAW_BITS-1:0]           i_offset_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_chip_select,
    output logic                          o_send_request,
    output logic                          o_reading_done,
    output logic signed [RAW_BITS:0]      o_pressure_one,
    output logic signed [RAW_BITS:0]      o_pressure_two,
    output logic [RAW_BITS-1:0]           o_offset_one,
    output logic [RAW_BITS-1:0]           o_offset_two,
    output logic                          o_save_offsets
);
    import dprc_pkg::*;

    localparam int SUM_BITS     = RAW_BITS + COUNT_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SUM_BITS - 1);
    localparam logic [COUNT_BITS-1:0]   CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0]   CNT_ONE  = COUNT_BITS'(1);

    t_func w_func;

    // architectural state
    logic [TICK_BITS-1:0]  r_period, n_period;
    t_phase                r_phase, n_phase;
    logic [WORD_BITS-1:0]  r_high, n_high;
    logic [RAW_BITS-1:0]   r_raw0, n_raw0, r_raw1, n_raw1;
    logic [RAW_BITS:0]     r_adj0, n_adj0, r_adj1, n_adj1;
    logic [RAW_BITS-1:0]   r_off0, n_off0, r_off1, n_off1;
    logic [SUM_BITS-1:0]   r_sum0, n_sum0, r_sum1, n_sum1;
    logic [COUNT_BITS-1:0] r_summed, n_summed;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic                  r_pending, n_pending;
    logic [TICK_BITS-1:0]  r_ticks, n_ticks;
    logic [1:0]            r_sel, n_sel;
    logic                  r_send_hold;

    // divider
    logic [SUM_BITS-1:0]     r_quo0, r_quo1, w_quo0_nx, w_quo1_nx;
    logic [COUNT_BITS-1:0]   r_rem0, r_rem1, w_rem0_nx, w_rem1_nx;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [COUNT_BITS:0]     w_try0, w_try1, w_dvs, w_diff0, w_diff1;
    logic                    w_div_last;

    // output register
    logic                r_out_valid;
    logic [1:0]          r_out_cs;
    logic                r_out_send, r_out_done, r_out_save;
    logic [RAW_BITS:0]   r_out_p1, r_out_p2;
    logic [RAW_BITS-1:0] r_out_o1, r_out_o2;

    logic                  w_send, w_done, w_save, w_cal_end;
    logic [TICK_BITS-1:0]  w_ticks_inc;
    logic [2*WORD_BITS-1:0] w_joined;
    logic [RAW_BITS-1:0]   w_raw_new;
    logic [RAW_BITS:0]     w_adj_new;

    assign w_func      = t_func'(i_func);
    assign w_cal_end   = (w_func == FN_TICK) && r_pending && (r_left == CNT_ONE);
    assign w_ticks_inc = (r_ticks != TICK_MAX) ? r_ticks + 1'b1 : r_ticks;
    assign w_joined    = {r_high, i_rx_word};
    assign w_raw_new   = w_joined[RAW_BITS-1:0];
    assign w_adj_new   = {1'b0, w_raw_new}
                       - {1'b0, (r_phase == PH_S2_LOW) ? r_off1 : r_off0};

    // restoring division, one quotient bit per cycle for both sums
    assign w_dvs      = {1'b0, r_summed};
    assign w_try0     = {r_rem0, r_quo0[SUM_BITS-1]};
    assign w_try1     = {r_rem1, r_quo1[SUM_BITS-1]};
    assign w_diff0    = w_try0 - w_dvs;
    assign w_diff1    = w_try1 - w_dvs;
    assign w_rem0_nx  = (w_try0 >= w_dvs) ? w_diff0[COUNT_BITS-1:0] : w_try0[COUNT_BITS-1:0];
    assign w_rem1_nx  = (w_try1 >= w_dvs) ? w_diff1[COUNT_BITS-1:0] : w_try1[COUNT_BITS-1:0];
    assign w_quo0_nx  = {r_quo0[SUM_BITS-2:0], (w_try0 >= w_dvs)};
    assign w_quo1_nx  = {r_quo1[SUM_BITS-2:0], (w_try1 >= w_dvs)};
    assign w_div_last = (r_div_cnt == DIV_LAST);

    always_comb begin
        n_period  = i_cfg_we ? i_cfg_data : r_period;
        n_phase   = r_phase;
        n_high    = r_high;
        n_raw0    = r_raw0;
        n_raw1    = r_raw1;
        n_adj0    = r_adj0;
        n_adj1    = r_adj1;
        n_off0    = r_off0;
        n_off1    = r_off1;
        n_sum0    = r_sum0;
        n_sum1    = r_sum1;
        n_summed  = r_summed;
        n_left    = r_left;
        n_pending = r_pending;
        n_ticks   = r_ticks;
        n_sel     = r_sel;
        w_send    = 1'b0;
        w_done    = 1'b0;
        w_save    = 1'b0;
        if (i_cmd.accept) begin
            case (w_func)
                FN_TICK: begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        if (r_left != '0) begin
                            n_sum0 = r_sum0 + SUM_BITS'(r_raw0);
                            n_sum1 = r_sum1 + SUM_BITS'(r_raw1);
                            if (r_summed != CNT_MAX) begin
                                n_summed = r_summed + 1'b1;
                            end
                            n_left = r_left - 1'b1;
                        end
                    end
                    if (w_ticks_inc >= r_period) begin
                        n_ticks = '0;
                        n_sel   = CS_ONE;
                        w_send  = 1'b1;
                        n_phase = PH_S1_HIGH;
                    end else begin
                        n_ticks = w_ticks_inc;
                    end
                end
                FN_WORD: begin
                    case (r_phase)
                        PH_S1_HIGH: begin
                            n_high  = i_rx_word;
                            n_phase = PH_S1_LOW;
                        end
                        PH_S1_LOW: begin
                            n_raw0  = w_raw_new;
                            n_adj0  = w_adj_new;
                            n_sel   = CS_TWO;
                            n_phase = PH_S2_HIGH;
                            w_send  = 1'b1;
                        end
                        PH_S2_HIGH: begin
                            n_high  = i_rx_word;
                            n_phase = PH_S2_LOW;
                        end
                        PH_S2_LOW: begin
                            n_raw1    = w_raw_new;
                            n_adj1    = w_adj_new;
                            n_sel     = CS_NONE;
                            n_phase   = PH_IDLE;
                            n_pending = 1'b1;
                            w_done    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                FN_CAL: begin
                    n_left   = i_cal_count;
                    n_sum0   = '0;
                    n_sum1   = '0;
                    n_summed = '0;
                end
                FN_LOAD: begin
                    if (i_sensor_sel) begin
                        n_off1 = i_offset_value;
                    end else begin
                        n_off0 = i_offset_value;
                    end
                    w_save = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_step && w_div_last) begin
            n_off0 = w_quo0_nx[RAW_BITS-1:0];
            n_off1 = w_quo1_nx[RAW_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RESET;
            r_phase   <= PH_IDLE;
            r_high    <= '0;
            r_raw0    <= '0;
            r_raw1    <= '0;
            r_adj0    <= '0;
            r_adj1    <= '0;
            r_off0    <= '0;
            r_off1    <= '0;
            r_sum0    <= '0;
            r_sum1    <= '0;
            r_summed  <= '0;
            r_left    <= '0;
            r_pending <= 1'b0;
            r_ticks   <= '0;
            r_sel     <= CS_NONE;
        end else begin
            r_period  <= n_period;
            r_phase   <= n_phase;
            r_high    <= n_high;
            r_raw0    <= n_raw0;
            r_raw1    <= n_raw1;
            r_adj0    <= n_adj0;
            r_adj1    <= n_adj1;
            r_off0    <= n_off0;
            r_off1    <= n_off1;
            r_sum0    <= n_sum0;
            r_sum1    <= n_sum1;
            r_summed  <= n_summed;
            r_left    <= n_left;
            r_pending <= n_pending;
            r_ticks   <= n_ticks;
            r_sel     <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_send_hold <= w_send;
            r_quo0      <= n_sum0;
            r_quo1      <= n_sum1;
            r_rem0      <= '0;
            r_rem1      <= '0;
            r_div_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_quo0    <= w_quo0_nx;
            r_quo1    <= w_quo1_nx;
            r_rem0    <= w_rem0_nx;
            r_rem1    <= w_rem1_nx;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cs   <= n_sel;
            r_out_send <= i_cmd.emit ? r_send_hold : w_send;
            r_out_done <= w_done;
            r_out_save <= i_cmd.emit | w_save;
            r_out_p1   <= n_adj0;
            r_out_p2   <= n_adj1;
            r_out_o1   <= n_off0;
            r_out_o2   <= n_off1;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.cal_end  = w_cal_end;
    assign o_sts.div_last = w_div_last;

    assign o_out_valid    = r_out_valid;
    assign o_chip_select  = r_out_cs;
    assign o_send_request = r_out_send;
    assign o_reading_done = r_out_done;
    assign o_pressure_one = $signed(r_out_p1);
    assign o_pressure_two = $signed(r_out_p2);
    assign o_offset_one   = r_out_o1;
    assign o_offset_two   = r_out_o2;
    assign o_save_offsets = r_out_save;

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_summed != '0))
        else $error("divide step with zero divisor");

    a_cal_end_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && w_cal_end) |=> (r_left == '0 && r_div_cnt == '0 && !r_pending))
        else $error("calibration end left stale count or divider state");

    a_done_deselects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_cs == CS_NONE && !r_out_send))
        else $error("reading done while a sensor is still selected");

endmodule

// File: sv/dual_pressure_read_offset_cal.sv
`timescale 1ns / 1ps
// result: registered, valid in the cycle after the input transaction is accepted
// calibration end: the result waits until the divider has finished both offsets
// throughput: one transaction per cycle while the output is free and the divider idle
// the divider is bit serial, one quotient bit per cycle for both offsets
// reset: synchronous active low; all but the divider and output data registers reset
module dual_pressure_read_offset_cal #(
    parameter int RAW_BITS   = dprc_pkg::RAW_BITS_DEF,
    parameter int COUNT_BITS = dprc_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dprc_cfg_if.sink    i_cfg,
    dprc_in_if.sink     i_in,
    dprc_out_if.source  o_out
);
    import dprc_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    assign i_cfg.ready = 1'b1;

    dprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dprc_dp #(
        .RAW_BITS   (RAW_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg.valid & i_cfg.ready),
        .i_cfg_data     (i_cfg.read_period_ticks),
        .i_func         (i_in.func),
        .i_rx_word      (i_in.rx_word),
        .i_cal_count    (i_in.cal_count),
        .i_sensor_sel   (i_in.sensor_sel),
        .i_offset_value (i_in.offset_value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_chip_select  (o_out.chip_select),
        .o_send_request (o_out.send_request),
        .o_reading_done (o_out.reading_done),
        .o_pressure_one (o_out.pressure_one),
        .o_pressure_two (o_out.pressure_two),
        .o_offset_one   (o_out.offset_one),
        .o_offset_two   (o_out.offset_two),
        .o_save_offsets (o_out.save_offsets)
    );

endmodule

// File: tb/sv/tb_dual_pressure_read_offset_cal.sv
`timescale 1ns / 1ps
import dprc_pkg::*;

typedef struct packed {
    t_func       func;
    logic [15:0] rx_word;
    logic [15:0] cal_count;
    logic        sensor_sel;
    logic [23:0] offset_value;
} sensor_cmd_t;

typedef struct packed {
    logic [1:0]  chip_select;
    logic        send_request;
    logic        reading_done;
    logic [24:0] pressure_one;
    logic [24:0] pressure_two;
    logic [23:0] offset_one;
    logic [23:0] offset_two;
    logic        save_offsets;
} sensor_status_t;

class pressure_scoreboard;
    logic [15:0]    period;
    t_phase         phase;
    logic [15:0]    high_word;
    logic [23:0]    raw [2];
    logic [24:0]    adjusted [2];
    logic [23:0]    offs [2];
    logic [39:0]    sums [2];
    logic [15:0]    summed;
    logic [15:0]    left;
    bit             fold_pending;
    logic [15:0]    ticks;
    logic [1:0]     sel;
    sensor_status_t status_q [$];
    int             errors;

    function new();
        period       = PERIOD_RESET;
        phase        = PH_IDLE;
        high_word    = '0;
        raw[0]       = '0;
        raw[1]       = '0;
        adjusted[0]  = '0;
        adjusted[1]  = '0;
        offs[0]      = '0;
        offs[1]      = '0;
        sums[0]      = '0;
        sums[1]      = '0;
        summed       = '0;
        left         = '0;
        fold_pending = 0;
        ticks        = '0;
        sel          = CS_NONE;
        errors       = 0;
    endfunction

    function void join_reading(int idx, logic [15:0] low);
        raw[idx]      = {high_word[7:0], low};
        adjusted[idx] = {1'b0, raw[idx]} - {1'b0, offs[idx]};
    endfunction

    function sensor_status_t step(sensor_cmd_t c);
        sensor_status_t r;
        logic [39:0]    q0;
        logic [39:0]    q1;
        r = '0;
        case (c.func)
            FN_TICK: begin
                if (fold_pending) begin
                    fold_pending = 0;
                    if (left != 16'd0) begin
                        sums[0] = sums[0] + {16'd0, raw[0]};
                        sums[1] = sums[1] + {16'd0, raw[1]};
                        if (summed != 16'hFFFF) summed = summed + 16'd1;
                        left = left - 16'd1;
                        if (left == 16'd0) begin
                            q0 = sums[0] / {24'd0, summed};
                            q1 = sums[1] / {24'd0, summed};
                            offs[0] = q0[23:0];
                            offs[1] = q1[23:0];
                            r.save_offsets = 1'b1;
                        end
                    end
                end
                if (ticks != TICK_MAX) ticks = ticks + 16'd1;
                if (ticks >= period) begin
                    ticks = '0;
                    sel = CS_ONE;
                    r.send_request = 1'b1;
                    phase = PH_S1_HIGH;
                end
            end
            FN_WORD: begin
                case (phase)
                    PH_S1_HIGH: begin
                        high_word = c.rx_word;
                        phase = PH_S1_LOW;
                    end
                    PH_S1_LOW: begin
                        join_reading(0, c.rx_word);
                        sel = CS_TWO;
                        phase = PH_S2_HIGH;
                        r.send_request = 1'b1;
                    end
                    PH_S2_HIGH: begin
                        high_word = c.rx_word;
                        phase = PH_S2_LOW;
                    end
                    PH_S2_LOW: begin
                        sel = CS_NONE;
                        join_reading(1, c.rx_word);
                        phase = PH_IDLE;
                        fold_pending = 1;
                        r.reading_done = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            FN_CAL: begin
                left    = c.cal_count;
                sums[0] = '0;
                sums[1] = '0;
                summed  = '0;
            end
            default: begin
                offs[c.sensor_sel] = c.offset_value;
                r.save_offsets = 1'b1;
            end
        endcase
        r.chip_select  = sel;
        r.pressure_one = adjusted[0];
        r.pressure_two = adjusted[1];
        r.offset_one   = offs[0];
        r.offset_two   = offs[1];
        return r;
    endfunction

    task report(string what);
        errors++;
        if (errors <= 20) $display("ERROR at %0t: %s", $time, what);
    endtask

    function void note_input(sensor_cmd_t c);
        status_q.push_back(step(c));
    endfunction

    task check_result(sensor_status_t got);
        sensor_status_t want;
        if (status_q.size() == 0) begin
            report("result arrived with no transaction outstanding");
            return;
        end
        want = status_q.pop_front();
        if (got.chip_select !== want.chip_select)
            report($sformatf("chip_select got %0d want %0d", got.chip_select,
                             want.chip_select));
        if (got.send_request !== want.send_request)
            report($sformatf("send_request got %0b want %0b", got.send_request,
                             want.send_request));
        if (got.reading_done !== want.reading_done)
            report($sformatf("reading_done got %0b want %0b", got.reading_done,
                             want.reading_done));
        if (got.pressure_one !== want.pressure_one)
            report($sformatf("pressure_one got %h want %h", got.pressure_one,
                             want.pressure_one));
        if (got.pressure_two !== want.pressure_two)
            report($sformatf("pressure_two got %h want %h", got.pressure_two,
                             want.pressure_two));
        if (got.offset_one !== want.offset_one)
            report($sformatf("offset_one got %h want %h", got.offset_one, want.offset_one));
        if (got.offset_two !== want.offset_two)
            report($sformatf("offset_two got %h want %h", got.offset_two, want.offset_two));
        if (got.save_offsets !== want.save_offsets)
            report($sformatf("save_offsets got %0b want %0b", got.save_offsets,
                             want.save_offsets));
    endtask
endclass

module tb_dual_pressure_read_offset_cal;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 60;

    logic i_clk;
    logic i_rst_n;

    dprc_cfg_if cfg_if ();
    dprc_in_if  in_if ();
    dprc_out_if out_if ();

    dual_pressure_read_offset_cal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    pressure_scoreboard sb   = new();
    pressure_scoreboard plan = new();

    bit idle_en  = 1;
    bit hold_req = 0;
    int n_sent   = 0;
    int n_results = 0;
    int n_reads  = 0;
    int n_saves  = 0;
    int n_writes = 0;
    int cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dual_pressure_read_offset_cal: mismatch");
            $finish;
        end
    end

    // transaction monitors
    always @(posedge i_clk) begin
        sensor_cmd_t    c;
        sensor_status_t s;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.period = cfg_if.read_period_ticks;
                n_writes++;
            end
            if (in_if.valid && in_if.ready) begin
                c.func         = t_func'(in_if.func);
                c.rx_word      = in_if.rx_word;
                c.cal_count    = in_if.cal_count;
                c.sensor_sel   = in_if.sensor_sel;
                c.offset_value = in_if.offset_value;
                sb.note_input(c);
            end
            if (out_if.valid && out_if.ready) begin
                s.chip_select  = out_if.chip_select;
                s.send_request = out_if.send_request;
                s.reading_done = out_if.reading_done;
                s.pressure_one = out_if.pressure_one;
                s.pressure_two = out_if.pressure_two;
                s.offset_one   = out_if.offset_one;
                s.offset_two   = out_if.offset_two;
                s.save_offsets = out_if.save_offsets;
                n_results++;
                if (s.reading_done === 1'b1) n_reads++;
                if (s.save_offsets === 1'b1) n_saves++;
                sb.check_result(s);
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int n;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic sensor_cmd_t rand_cmd();
        sensor_cmd_t c;
        c.func         = t_func'($urandom_range(0, 3));
        c.rx_word      = 16'($urandom);
        c.cal_count    = 16'($urandom);
        c.sensor_sel   = 1'($urandom);
        c.offset_value = 24'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_cmd(input sensor_cmd_t c, output sensor_status_t r);
        int n;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.func         <= c.func;
        in_if.rx_word      <= c.rx_word;
        in_if.cal_count    <= c.cal_count;
        in_if.sensor_sel   <= c.sensor_sel;
        in_if.offset_value <= c.offset_value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        r = plan.step(c);
        n_sent++;
    endtask

    task automatic do_tick(output sensor_status_t r);
        sensor_cmd_t c;
        c = rand_cmd();
        c.func = FN_TICK;
        send_cmd(c, r);
    endtask

    task automatic do_word(input logic [15:0] w);
        sensor_cmd_t    c;
        sensor_status_t r;
        c = rand_cmd();
        c.func = FN_WORD;
        c.rx_word = w;
        send_cmd(c, r);
    endtask

    task automatic do_cal(input logic [15:0] n);
        sensor_cmd_t    c;
        sensor_status_t r;
        c = rand_cmd();
        c.func = FN_CAL;
        c.cal_count = n;
        send_cmd(c, r);
    endtask

    task automatic do_load(input logic s, input logic [23:0] v);
        sensor_cmd_t    c;
        sensor_status_t r;
        c = rand_cmd();
        c.func = FN_LOAD;
        c.sensor_sel = s;
        c.offset_value = v;
        send_cmd(c, r);
    endtask

    task automatic start_read();
        sensor_status_t r;
        do_tick(r);
        while (!r.send_request) do_tick(r);
    endtask

    task automatic full_read(input logic [15:0] h1, input logic [15:0] l1,
                             input logic [15:0] h2, input logic [15:0] l2);
        start_read();
        do_word(h1);
        do_word(l1);
        do_word(h2);
        do_word(l2);
    endtask

    task automatic write_period(input logic [15:0] v);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.read_period_ticks <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        plan.period = v;
    endtask

    task automatic random_episode();
        sensor_status_t r;
        int k;
        int n;
        k = $urandom_range(0, 99);
        if (k < 62) begin
            full_read(rand_word(), rand_word(), rand_word(), rand_word());
        end else if (k < 70) begin
            // broken sequence, a later read start restarts it
            start_read();
            n = $urandom_range(0, 3);
            repeat (n) do_word(rand_word());
        end else if (k < 78) begin
            if ($urandom_range(0, 19) == 0) do_cal(16'($urandom));
            else do_cal(16'($urandom_range(0, 4)));
        end else if (k < 84) begin
            do_load(1'($urandom), ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom));
        end else if (k < 92) begin
            send_cmd(rand_cmd(), r);
        end else begin
            do_tick(r);
        end
    endtask

    task automatic run_phase(input logic [15:0] p, input int n_items, input bit with_hold);
        int stop_at;
        write_period(p);
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if (with_hold && n_sent > stop_at - n_items + 20) begin
                hold_req = 1;
                with_hold = 0;
            end
            random_episode();
        end
    endtask

    initial begin
        sensor_status_t r;
        int stop_at;
        i_rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.read_period_ticks <= '0;
        in_if.valid <= 1'b0;
        in_if.func <= FN_TICK;
        in_if.rx_word <= '0;
        in_if.cal_count <= '0;
        in_if.sensor_sel <= 1'b0;
        in_if.offset_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        write_period(16'd1);
        do_word(16'hFFFF);
        full_read(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        do_load(1'b0, 24'hFFFFFF);
        do_load(1'b1, 24'h000001);
        full_read(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        do_cal(16'd2);
        full_read(rand_word(), rand_word(), rand_word(), rand_word());
        full_read(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        do_tick(r);
        do_word(16'h1234);
        do_tick(r);
        do_cal(16'd0);
        do_cal(16'hFFFF);
        do_cal(16'd1);
        full_read(16'h00AA, 16'h5555, 16'hFF55, 16'hAAAA);
        do_load(1'b1, 24'h000000);

        // random part over several periods
        run_phase(16'd0, 110, 0);
        run_phase(16'd3, 110, 1);
        write_period(16'hFFFF);
        stop_at = n_sent + 20;
        while (n_sent < stop_at) send_cmd(rand_cmd(), r);
        run_phase(16'($urandom_range(1, 8)), 110, 0);
        idle_en = 0;
        run_phase(16'd2, 140, 0);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.status_q.size() != 0) sb.report("expected results left over");

        $display("run covered %0d input transactions, %0d results, %0d register writes",
                 n_sent, n_results, n_writes);
        $display("including %0d completed two-sensor reads and %0d offset updates",
                 n_reads, n_saves);
        if (sb.errors == 0) begin
            $display("dual_pressure_read_offset_cal: match");
        end else begin
            $display("dual_pressure_read_offset_cal: mismatch");
        end
        $finish;
    end
endmodule
